// ===== hw/rtl/aescbc_pkg.sv =====
package aescbc_pkg;

    localparam int NbBytes = 16;
    localparam int NumRounds = 10;
    localparam int NumWords = 44;

    localparam logic [1:0] REG_KEY_HIGH = 2'd0;
    localparam logic [1:0] REG_KEY_LOW  = 2'd1;
    localparam logic [1:0] REG_IV_HIGH  = 2'd2;
    localparam logic [1:0] REG_IV_LOW   = 2'd3;

    typedef struct packed {
        logic [63:0] plain_high;
        logic [63:0] plain_low;
        logic [4:0]  valid_bytes;
        logic        first_block;
    } in_item_t;

    typedef struct packed {
        logic [63:0] cipher_high;
        logic [63:0] cipher_low;
    } out_item_t;

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] r;
        case (x)
            8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
            8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
            8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
            8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
            8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
            8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
            8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
            8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
            8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
            8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
            8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
            8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
            8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
            8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
            8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
            8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
            8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
            8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
            8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
            8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
            8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
            8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
            8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
            8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
            8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
            8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
            8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
            8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
            8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
            8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
            8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
            8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
            8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
            8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
            8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
            8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
            8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
            8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
            8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
            8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
            8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
            8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
            8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
            8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
            8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
            8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
            8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
            8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
            8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
            8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
            8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
            8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
            8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
            8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
            8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
            8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
            8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
            8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
            8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
            8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
            8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
            8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
            8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
            8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] rcon(input logic [3:0] r);
        logic [7:0] v;
        case (r)
            4'd1: v = 8'h01; 4'd2: v = 8'h02; 4'd3: v = 8'h04; 4'd4: v = 8'h08;
            4'd5: v = 8'h10; 4'd6: v = 8'h20; 4'd7: v = 8'h40; 4'd8: v = 8'h80;
            4'd9: v = 8'h1b; 4'd10: v = 8'h36;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/aes128_cbc_pkcs7_encrypt.sv =====
// AES-128 CBC encryptor with PKCS#7 padding of a short last block.
// Input channel: in_valid / in_stall / in_data (plaintext, valid byte count,
// first-block flag). Output channel: out_valid / out_stall / out_data.
// Configuration: cfg_we / cfg_index / cfg_data writes key and IV registers;
// write only while idle. A key write takes effect on the next block at once:
// round keys are generated on the fly from the stored key, with no pass.
// One shared round unit (sixteen S-boxes, MixColumns, AddRoundKey) runs one
// round per cycle. A block is loaded at acceptance with pad, chain XOR and
// the first key addition; the round unit then runs the remaining rounds and
// the last round writes the result into the output register. Once the result
// is taken the block goes back to idle before it accepts another request.
// The result sits in an output register; a stall holds it and the next
// request is accepted only once it is taken. Reset clears key, IV and chain
// value to zero; the all-zero key needs no expansion pass since round keys
// are generated on the fly from round key 0.
module aes128_cbc_pkcs7_encrypt (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  aescbc_pkg::in_item_t   in_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output aescbc_pkg::out_item_t  out_data,
    input  logic                   cfg_we,
    input  logic [1:0]             cfg_index,
    input  logic [63:0]            cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]   state_reg, state_next;
    logic [3:0]   round_reg;
    logic [127:0] key_reg, iv_reg, chain_reg;
    logic [127:0] st_reg;
    logic [127:0] rk_reg;
    logic [127:0] blk, cv, s0, sb, mc, rk_next, rnd_out;
    logic [31:0]  tw;
    logic         accept;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_DONE);
    assign out_data.cipher_high = chain_reg[127:64];
    assign out_data.cipher_low  = chain_reg[63:0];

    // Pad the block, fold in the chaining value and add round key 0
    always_comb
    begin
        blk = {in_data.plain_high, in_data.plain_low};
        for (int i = 0; i < aescbc_pkg::NbBytes; i++)
        begin
            if ({27'd0, in_data.valid_bytes} <= i && in_data.valid_bytes < 5'd16)
            begin
                blk[127-8*i -: 8] = 8'd16 - {3'd0, in_data.valid_bytes};
            end
        end
        cv = in_data.first_block ? iv_reg : chain_reg;
        s0 = blk ^ cv ^ key_reg;
    end

    // Next round key from the current one
    always_comb
    begin
        tw = {aescbc_pkg::sbox(rk_reg[23:16]), aescbc_pkg::sbox(rk_reg[15:8]),
              aescbc_pkg::sbox(rk_reg[7:0]), aescbc_pkg::sbox(rk_reg[31:24])};
        tw[31:24] = tw[31:24] ^ aescbc_pkg::rcon(round_reg);
        rk_next[127:96] = rk_reg[127:96] ^ tw;
        rk_next[95:64]  = rk_reg[95:64] ^ rk_next[127:96];
        rk_next[63:32]  = rk_reg[63:32] ^ rk_next[95:64];
        rk_next[31:0]   = rk_reg[31:0] ^ rk_next[63:32];
    end

    // Shared round: SubBytes, ShiftRows, MixColumns (skipped in the last round), AddRoundKey
    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                sb[127-8*(c*4+r) -: 8] = aescbc_pkg::sbox(st_reg[127-8*(((c+r)%4)*4+r) -: 8]);
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            logic [7:0] a0, a1, a2, a3, al;
            a0 = sb[127-32*c -: 8];
            a1 = sb[119-32*c -: 8];
            a2 = sb[111-32*c -: 8];
            a3 = sb[103-32*c -: 8];
            al = a0 ^ a1 ^ a2 ^ a3;
            mc[127-32*c -: 8] = a0 ^ al ^ aescbc_pkg::xtime(a0 ^ a1);
            mc[119-32*c -: 8] = a1 ^ al ^ aescbc_pkg::xtime(a1 ^ a2);
            mc[111-32*c -: 8] = a2 ^ al ^ aescbc_pkg::xtime(a2 ^ a3);
            mc[103-32*c -: 8] = a3 ^ al ^ aescbc_pkg::xtime(a3 ^ a0);
        end
        rnd_out = ((round_reg == 4'd10) ? sb : mc) ^ rk_next;
    end

    // Sequence the rounds
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept) state_next = ST_RUN;
            ST_RUN:  if (round_reg == 4'd10) state_next = ST_DONE;
            ST_DONE: if (!out_stall) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            round_reg <= 4'd0;
            key_reg   <= '0;
            iv_reg    <= '0;
            chain_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    aescbc_pkg::REG_KEY_HIGH: key_reg[127:64] <= cfg_data;
                    aescbc_pkg::REG_KEY_LOW:  key_reg[63:0]   <= cfg_data;
                    aescbc_pkg::REG_IV_HIGH:  iv_reg[127:64]  <= cfg_data;
                    aescbc_pkg::REG_IV_LOW:   iv_reg[63:0]    <= cfg_data;
                    default: ;
                endcase
            end
            if (accept)
            begin
                round_reg <= 4'd1;
            end
            else if (state_reg == ST_RUN)
            begin
                round_reg <= round_reg + 4'd1;
                if (round_reg == 4'd10)
                begin
                    chain_reg <= rnd_out;
                end
            end
        end
    end

    // Hold state and round key datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            st_reg <= s0;
            rk_reg <= key_reg;
        end
        else if (state_reg == ST_RUN)
        begin
            st_reg <= rnd_out;
            rk_reg <= rk_next;
        end
    end

    a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN |-> (round_reg >= 4'd1 && round_reg <= 4'd10))
        else $error("round counter out of range");
    a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && round_reg == 4'd10) |=> out_valid)
        else $error("result missing after last round");
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(chain_reg)))
        else $error("stalled result changed");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> in_stall)
        else $error("request accepted while busy");

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IdleLimit = 5000;
    localparam int NumRandom = 1250;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    aescbc_pkg::in_item_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    aescbc_pkg::out_item_t out_data;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [63:0] cfg_data = '0;

    aes128_cbc_pkcs7_encrypt dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // Cipher state mirrored by the testbench
    logic [63:0] key_hi, key_lo, iv_hi, iv_lo;
    logic [127:0] prev_cipher;
    logic [31:0] sched [44];
    aescbc_pkg::out_item_t cipher_queue [$];
    int fail_count = 0;
    int idle_cycles = 0;
    bit calm_stretch = 1'b0;

    // Substitution table built once from GF(2^8) inversion and the affine map
    logic [7:0] sub_table [256];

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                p ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return p;
    endfunction

    function automatic logic [7:0] rotl8(input logic [7:0] x, input int n);
        return (x << n) | (x >> (8 - n));
    endfunction

    task automatic build_sub_table();
        logic [7:0] inv;
        for (int x = 0; x < 256; x++)
        begin
            inv = '0;
            for (int y = 1; y < 256; y++)
                if (gmul(x[7:0], y[7:0]) == 8'h01)
                    inv = y[7:0];
            sub_table[x] = inv ^ rotl8(inv, 1) ^ rotl8(inv, 2) ^ rotl8(inv, 3)
                ^ rotl8(inv, 4) ^ 8'h63;
        end
    endtask

    function automatic logic [7:0] dbl(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    task automatic expand_schedule();
        logic [31:0] t;
        logic [7:0] rc;
        sched[0] = key_hi[63:32];
        sched[1] = key_hi[31:0];
        sched[2] = key_lo[63:32];
        sched[3] = key_lo[31:0];
        rc = 8'h01;
        for (int i = 4; i < 44; i++)
        begin
            t = sched[i-1];
            if (i % 4 == 0)
            begin
                t = {t[23:0], t[31:24]};
                t = {sub_table[t[31:24]], sub_table[t[23:16]],
                     sub_table[t[15:8]], sub_table[t[7:0]]};
                t ^= {rc, 24'h0};
                rc = dbl(rc);
            end
            sched[i] = sched[i-4] ^ t;
        end
    endtask

    // Pad, chain and encrypt one block; keep the ciphertext for chaining
    function automatic aescbc_pkg::out_item_t encrypt_block(input aescbc_pkg::in_item_t req);
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [127:0] blk, cv;
        logic [7:0] a0, a1, a2, a3, all;
        logic [31:0] w;
        aescbc_pkg::out_item_t res;
        blk = {req.plain_high, req.plain_low};
        cv = req.first_block ? {iv_hi, iv_lo} : prev_cipher;
        for (int i = 0; i < 16; i++)
        begin
            s[i] = blk[127 - 8*i -: 8];
            if (req.valid_bytes < 16 && i >= req.valid_bytes)
                s[i] = 8'(16 - req.valid_bytes);
            s[i] ^= cv[127 - 8*i -: 8];
        end
        for (int r = 0; r <= 10; r++)
        begin
            if (r > 0)
            begin
                for (int c = 0; c < 4; c++)
                    for (int k = 0; k < 4; k++)
                        t[c*4+k] = sub_table[s[((c+k)%4)*4+k]];
                s = t;
                if (r < 10)
                    for (int c = 0; c < 4; c++)
                    begin
                        a0 = s[c*4]; a1 = s[c*4+1]; a2 = s[c*4+2]; a3 = s[c*4+3];
                        all = a0 ^ a1 ^ a2 ^ a3;
                        s[c*4]   = a0 ^ all ^ dbl(a0 ^ a1);
                        s[c*4+1] = a1 ^ all ^ dbl(a1 ^ a2);
                        s[c*4+2] = a2 ^ all ^ dbl(a2 ^ a3);
                        s[c*4+3] = a3 ^ all ^ dbl(a3 ^ a0);
                    end
            end
            for (int c = 0; c < 4; c++)
            begin
                w = sched[r*4+c];
                for (int k = 0; k < 4; k++)
                    s[c*4+k] ^= w[31 - 8*k -: 8];
            end
        end
        for (int i = 0; i < 16; i++)
            blk[127 - 8*i -: 8] = s[i];
        prev_cipher = blk;
        res.cipher_high = blk[127:64];
        res.cipher_low = blk[63:0];
        return res;
    endfunction

    // Drive one register write; the caller drops the write enable afterwards
    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            aescbc_pkg::REG_KEY_HIGH: begin key_hi = val; expand_schedule(); end
            aescbc_pkg::REG_KEY_LOW:  begin key_lo = val; expand_schedule(); end
            aescbc_pkg::REG_IV_HIGH:  iv_hi = val;
            aescbc_pkg::REG_IV_LOW:   iv_lo = val;
            default: ;
        endcase
    endtask

    // Offer one request, idling at random, and record its prediction on acceptance
    task automatic send_block(input aescbc_pkg::in_item_t req);
        while (!calm_stretch && $urandom_range(99) < 19)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= req;
        do
            @(posedge clk);
        while (in_stall);
        cipher_queue.push_back(encrypt_block(req));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (cipher_queue.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // Check responses against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (cipher_queue.size() == 0)
            begin
                $error("unexpected response %h", out_data);
                fail_count++;
            end
            else
            begin
                if (out_data.cipher_high !== cipher_queue[0].cipher_high)
                begin
                    $error("cipher_high expected %h actual %h",
                           cipher_queue[0].cipher_high, out_data.cipher_high);
                    fail_count++;
                end
                if (out_data.cipher_low !== cipher_queue[0].cipher_low)
                begin
                    $error("cipher_low expected %h actual %h",
                           cipher_queue[0].cipher_low, out_data.cipher_low);
                    fail_count++;
                end
                void'(cipher_queue.pop_front());
            end
        end
    end

    // Stall the response side at random
    always @(posedge clk)
        out_stall <= !calm_stretch && ($urandom_range(99) < 19);

    // Watchdog on accepted traffic
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit)
        begin
            $display("status: fail");
            $finish;
        end
    end

    typedef struct {
        aescbc_pkg::in_item_t req;
        bit known;
        logic [127:0] cipher;
    } vector_t;

    function automatic aescbc_pkg::in_item_t rand_block();
        aescbc_pkg::in_item_t r;
        r.plain_high = {$urandom, $urandom};
        r.plain_low = {$urandom, $urandom};
        r.valid_bytes = ($urandom_range(3) == 0) ? 5'($urandom_range(31)) : 5'd16;
        r.first_block = ($urandom_range(7) == 0);
        return r;
    endfunction

    vector_t vectors [$];
    aescbc_pkg::in_item_t req;
    aescbc_pkg::out_item_t dummy;

    initial
    begin
        build_sub_table();
        key_hi = '0; key_lo = '0; iv_hi = '0; iv_lo = '0;
        prev_cipher = '0;
        expand_schedule();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: zero key, zero chain gives the well-known zero-block cipher
        vectors.push_back('{'{64'h0, 64'h0, 5'd16, 1'b0}, 1'b1,
                           128'h66e94bd4ef8a2c3b884cfa59ca342b2e});
        vectors.push_back('{'{64'h0, 64'h0, 5'd16, 1'b1}, 1'b1,
                           128'h66e94bd4ef8a2c3b884cfa59ca342b2e});
        vectors.push_back('{'{'1, '1, 5'd16, 1'b0}, 1'b0, '0});
        vectors.push_back('{'{'1, '1, 5'd0, 1'b1}, 1'b0, '0});
        vectors.push_back('{'{'1, '1, 5'd1, 1'b0}, 1'b0, '0});
        vectors.push_back('{'{'1, '1, 5'd15, 1'b0}, 1'b0, '0});
        vectors.push_back('{'{'1, '1, 5'd17, 1'b0}, 1'b0, '0});
        vectors.push_back('{'{'1, '1, 5'd31, 1'b1}, 1'b0, '0});
        vectors.push_back('{'{64'h0123456789abcdef, 64'hfedcba9876543210, 5'd8, 1'b0},
                           1'b0, '0});
        foreach (vectors[i])
        begin
            dummy = encrypt_block(vectors[i].req);
            prev_cipher = (i == 0) ? 128'h0 : prev_cipher;
        end
        // Replay the table from the reset chain value
        prev_cipher = '0;
        foreach (vectors[i])
        begin
            send_block(vectors[i].req);
            if (vectors[i].known &&
                {cipher_queue[$].cipher_high, cipher_queue[$].cipher_low}
                    !== vectors[i].cipher)
            begin
                $error("table cipher expected %h got %h", vectors[i].cipher,
                       {cipher_queue[$].cipher_high, cipher_queue[$].cipher_low});
                fail_count++;
            end
        end
        drain();

        // Random phases across register settings, extremes first
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: begin
                    write_reg(aescbc_pkg::REG_KEY_HIGH, '1);
                    write_reg(aescbc_pkg::REG_KEY_LOW, '1);
                    write_reg(aescbc_pkg::REG_IV_HIGH, '1);
                    write_reg(aescbc_pkg::REG_IV_LOW, '1);
                end
                1: begin
                    write_reg(aescbc_pkg::REG_KEY_HIGH, '0);
                    write_reg(aescbc_pkg::REG_KEY_LOW, '0);
                    write_reg(aescbc_pkg::REG_IV_HIGH, '0);
                    write_reg(aescbc_pkg::REG_IV_LOW, '0);
                end
                default: begin
                    write_reg(aescbc_pkg::REG_KEY_HIGH, {$urandom, $urandom});
                    write_reg(aescbc_pkg::REG_KEY_LOW, {$urandom, $urandom});
                    write_reg(aescbc_pkg::REG_IV_HIGH, {$urandom, $urandom});
                    write_reg(aescbc_pkg::REG_IV_LOW, {$urandom, $urandom});
                end
            endcase
            cfg_we <= 1'b0;
            // Round keys follow the new key at once; no wait is needed
            for (int n = 0; n < NumRandom / 5; n++)
            begin
                calm_stretch = (ph == 2) && (n >= 50) && (n < 150);
                req = rand_block();
                if (n == 0)
                    req.first_block = 1'b1;
                send_block(req);
            end
            calm_stretch = 1'b0;
            drain();
        end

        if (fail_count == 0 && cipher_queue.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
